@@ src/vec3_fixed_point_alu_top_defines.svh @@
// Assertion macros for the vector ALU top module.
`ifndef VEC3_FIXED_POINT_ALU_TOP_DEFINES_SVH
`define VEC3_FIXED_POINT_ALU_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define VFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vector ALU implication check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define VFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vector ALU next-cycle check failed");

`endif

@@ src/vfa_pkg.sv @@
// Types and constants shared by the vector ALU modules.
`default_nettype none
package vfa_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_LENSQ = 4'd7,
        OP_LEN   = 4'd8,
        OP_UNIT  = 4'd9,
        OP_NEG   = 4'd10,
        OP_GET   = 4'd11,
        OP_SET   = 4'd12
    } t_op;

    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 32;
    // abs stage, range check stage, quotient steps, sign/saturate stage
    localparam int DIV_LAT    = DIV_STEPS + 3;

    localparam logic signed [31:0] W32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W32_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] t_word;
    typedef t_word [2:0] t_vec;

    typedef struct packed {
        t_op         op;
        t_vec        a;
        t_vec        b;
        t_word       s;
        logic [1:0]  idx;
    } t_in;

    typedef struct packed {
        t_op    op;
        t_vec   res;
        t_word  sc;
        logic   ov;
        t_vec   b;
        t_word  s;
    } t_mid;

    typedef struct packed {
        logic   use_div;
        t_vec   res;
        t_word  sc;
        logic   ov;
    } t_fin;

    typedef struct packed {
        logic neg;
        logic num_neg;
        logic num_zero;
        logic big;
        logic dz;
    } t_dflag;

    typedef struct packed {
        t_word  q;
        logic   ovf;
        logic   dz;
    } t_dres;

endpackage
`default_nettype wire

@@ src/vfa_lane.sv @@
// One component lane: operand select, two products, product difference.
`default_nettype none
module vfa_lane (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire vfa_pkg::t_op       i_op,
    input  wire vfa_pkg::t_word     i_a_own,
    input  wire vfa_pkg::t_word     i_b_own,
    input  wire vfa_pkg::t_word     i_a_j,
    input  wire vfa_pkg::t_word     i_b_k,
    input  wire vfa_pkg::t_word     i_a_k,
    input  wire vfa_pkg::t_word     i_b_j,
    input  wire vfa_pkg::t_word     i_s,
    output logic signed [64:0]      o_psum
);

    vfa_pkg::t_word x0, y0, x1, y1;
    logic signed [63:0] r_p0, r_p1;
    logic signed [64:0] r_psum;

    // pick multiplier operands for the op
    always_comb begin
        x0 = '0;
        y0 = '0;
        x1 = '0;
        y1 = '0;
        unique case (i_op) inside
            vfa_pkg::OP_MUL, vfa_pkg::OP_DOT: begin
                x0 = i_a_own;
                y0 = i_b_own;
            end
            vfa_pkg::OP_SCALE: begin
                x0 = i_b_own;
                y0 = i_s;
            end
            vfa_pkg::OP_LENSQ, vfa_pkg::OP_LEN, vfa_pkg::OP_UNIT: begin
                x0 = i_b_own;
                y0 = i_b_own;
            end
            vfa_pkg::OP_CROSS: begin
                x0 = i_a_j;
                y0 = i_b_k;
                x1 = i_a_k;
                y1 = i_b_j;
            end
            default: begin
                x0 = '0;
            end
        endcase
    end

    // register products, then their difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= x0 * y0;
            r_p1   <= x1 * y1;
            r_psum <= {r_p0[63], r_p0} - {r_p1[63], r_p1};
        end
    end

    assign o_psum = r_psum;

endmodule
`default_nettype wire

@@ src/vfa_sqrt.sv @@
// Pipelined square root, one result bit per stage, rounded to nearest.
`default_nettype none
module vfa_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [63:0]    i_x,
    input  wire vfa_pkg::t_mid  i_pay,
    output logic                o_valid,
    output logic [32:0]         o_root,
    output vfa_pkg::t_mid       o_pay
);

    localparam int N = vfa_pkg::SQRT_STEPS;

    logic [63:0]    r_rem  [0:N-1];
    logic [63:0]    r_root [0:N-1];
    vfa_pkg::t_mid  r_pay  [0:N-1];
    logic           r_v    [0:N-1];
    logic [32:0]    r_out_root;
    vfa_pkg::t_mid  r_out_pay;
    logic           r_out_v;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [63:0]   rem_in, root_in, bitv, trial;
        vfa_pkg::t_mid pay_in;
        logic          v_in;

        if (k == 0) begin : g_first
            assign rem_in  = i_x;
            assign root_in = '0;
            assign pay_in  = i_pay;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign pay_in  = r_pay[k-1];
            assign v_in    = r_v[k-1];
        end

        assign bitv  = 64'd1 << (62 - 2 * k);
        assign trial = root_in + bitv;

        // try the next root bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= (root_in >> 1) + bitv;
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in >> 1;
                end
                r_pay[k] <= pay_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end
    end

    // round up when the remainder passes the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_root <= r_root[N-1][32:0] +
                          ((r_rem[N-1] > r_root[N-1]) ? 33'd1 : 33'd0);
            r_out_pay  <= r_pay[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[N-1];
        end
    end

    assign o_valid = r_out_v;
    assign o_root  = r_out_root;
    assign o_pay   = r_out_pay;

endmodule
`default_nettype wire

@@ src/vfa_div.sv @@
// Pipelined signed fixed-point divider lane, one quotient bit per stage.
`default_nettype none
module vfa_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire vfa_pkg::t_word     i_num,
    input  wire logic signed [33:0] i_den,
    output vfa_pkg::t_dres          o_res
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int N     = vfa_pkg::DIV_STEPS;

    logic [32:0]          nabs;
    logic [33:0]          dabs;
    logic [NUM_W-1:0]     r_nm;
    logic [32:0]          r_dm0;
    vfa_pkg::t_dflag      r_fa;
    logic [32:0]          hi;

    logic [32:0]          r_rem [0:N];
    logic [31:0]          r_nq  [0:N];
    logic [32:0]          r_dm  [0:N];
    vfa_pkg::t_dflag      r_fl  [0:N];
    vfa_pkg::t_dres       r_res;

    // take magnitudes and the result sign
    assign nabs = i_num[31] ? (33'd0 - {1'b1, i_num}) : {1'b0, i_num};
    assign dabs = i_den[33] ? (34'd0 - i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm          <= {nabs[31:0], {FRAC_BITS{1'b0}}};
            r_dm0         <= dabs[32:0];
            r_fa.neg      <= i_num[31] ^ i_den[33];
            r_fa.num_neg  <= i_num[31];
            r_fa.num_zero <= (i_num == '0);
            r_fa.big      <= 1'b0;
            r_fa.dz       <= 1'b0;
        end
    end

    // range check: quotient needs more than 32 bits when the top part reaches the divisor
    assign hi = 33'(r_nm[NUM_W-1:32]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]          <= hi;
            r_nq[0]           <= r_nm[31:0];
            r_dm[0]           <= r_dm0;
            r_fl[0].neg       <= r_fa.neg;
            r_fl[0].num_neg   <= r_fa.num_neg;
            r_fl[0].num_zero  <= r_fa.num_zero;
            r_fl[0].big       <= (hi >= r_dm0);
            r_fl[0].dz        <= (r_dm0 == '0);
        end
    end

    // restoring division steps
    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [33:0] t;
        logic        take;

        assign t    = {r_rem[k-1], r_nq[k-1][31]};
        assign take = (t >= {1'b0, r_dm[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? 33'(t - {1'b0, r_dm[k-1]}) : t[32:0];
                r_nq[k]  <= {r_nq[k-1][30:0], take};
                r_dm[k]  <= r_dm[k-1];
                r_fl[k]  <= r_fl[k-1];
            end
        end
    end

    // apply sign, saturate, handle a zero divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.ovf <= 1'b0;
            r_res.dz  <= 1'b0;
            if (r_fl[N].dz) begin
                r_res.dz <= 1'b1;
                if (r_fl[N].num_zero) begin
                    r_res.q <= '0;
                end else if (r_fl[N].num_neg) begin
                    r_res.q <= vfa_pkg::W32_MIN;
                end else begin
                    r_res.q <= vfa_pkg::W32_MAX;
                end
            end else if (r_fl[N].neg) begin
                if (r_fl[N].big || (r_nq[N] > 32'h8000_0000)) begin
                    r_res.q   <= vfa_pkg::W32_MIN;
                    r_res.ovf <= 1'b1;
                end else begin
                    r_res.q <= 32'd0 - r_nq[N];
                end
            end else begin
                if (r_fl[N].big || r_nq[N][31]) begin
                    r_res.q   <= vfa_pkg::W32_MAX;
                    r_res.ovf <= 1'b1;
                end else begin
                    r_res.q <= r_nq[N];
                end
            end
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

@@ src/vec3_fixed_point_alu_top.sv @@
// Throughput: one item per cycle while the output is taken; the 32-step root
// and the 32-step quotient pipelines set the depth.
// A stalled output freezes the whole pipeline and drops input ready.
// Reset (synchronous, active low) clears all valid bits; data registers keep their values.
`default_nettype none
module vec3_fixed_point_alu_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // op[3:0], vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scale, comp_index[1:0]
    input  wire logic [231:0]   i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    // res_x, res_y, res_z, res_scalar, overflow, div_zero
    output logic [135:0]        o_m_axis_tdata
);

`include "vec3_fixed_point_alu_top_defines.svh"

    localparam int DL = vfa_pkg::DIV_LAT;

    logic                   adv;
    logic                   r_v0, r_v1, r_v2, r_v3, r_v4;
    vfa_pkg::t_in           r_s0, r_d1, r_d2, r_d3;
    logic signed [64:0]     psum [0:2];
    logic signed [64:0]     r_p3 [0:2];
    logic signed [65:0]     r_dot3;
    vfa_pkg::t_mid          n_m4, r_m4;
    logic [63:0]            r_sq4;
    logic                   sq_v;
    logic [32:0]            sq_len;
    vfa_pkg::t_mid          sq_pay;
    vfa_pkg::t_fin          n_fin;
    vfa_pkg::t_fin          r_fin [0:DL-1];
    logic                   r_fv  [0:DL-1];
    vfa_pkg::t_dres         dres  [0:2];
    logic                   r_out_valid;
    vfa_pkg::t_vec          r_res;
    vfa_pkg::t_word         r_sc;
    logic                   r_ov, r_dz;

    function automatic logic [32:0] round_sat(input logic signed [65:0] v);
        logic signed [66:0] t;
        logic signed [66:0] q;
        t = {v[65], v} + (67'sd1 <<< (FRAC_BITS - 1));
        q = t >>> FRAC_BITS;
        if (q > 67'sd2147483647) begin
            return {1'b1, vfa_pkg::W32_MAX};
        end else if (q < -67'sd2147483648) begin
            return {1'b1, vfa_pkg::W32_MIN};
        end
        return {1'b0, q[31:0]};
    endfunction

    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return {1'b1, vfa_pkg::W32_MAX};
        end else if (v < -33'sd2147483648) begin
            return {1'b1, vfa_pkg::W32_MIN};
        end
        return {1'b0, v[31:0]};
    endfunction

    // advance every stage unless a result waits at the output
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0.op  <= vfa_pkg::t_op'(i_s_axis_tdata[3:0]);
            r_s0.a   <= i_s_axis_tdata[99:4];
            r_s0.b   <= i_s_axis_tdata[195:100];
            r_s0.s   <= i_s_axis_tdata[227:196];
            r_s0.idx <= i_s_axis_tdata[229:228];
            r_d1     <= r_s0;
            r_d2     <= r_d1;
            r_d3     <= r_d2;
        end
    end

    // product lanes
    for (genvar i = 0; i < 3; i++) begin : g_lane
        vfa_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_op    (r_s0.op),
            .i_a_own (r_s0.a[i]),
            .i_b_own (r_s0.b[i]),
            .i_a_j   (r_s0.a[(i + 1) % 3]),
            .i_b_k   (r_s0.b[(i + 2) % 3]),
            .i_a_k   (r_s0.a[(i + 2) % 3]),
            .i_b_j   (r_s0.b[(i + 1) % 3]),
            .i_s     (r_s0.s),
            .o_psum  (psum[i])
        );
    end

    // register the lane results and merge them into the dot sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p3[i] <= psum[i];
            end
            r_dot3 <= {psum[0][64], psum[0]} + {psum[1][64], psum[1]} +
                      {psum[2][64], psum[2]};
        end
    end

    // round, saturate and finish everything that needs no root or quotient
    always_comb begin
        logic [32:0] rs;
        rs       = '0;
        n_m4     = '0;
        n_m4.op  = r_d3.op;
        n_m4.b   = r_d3.b;
        n_m4.s   = r_d3.s;
        case (r_d3.op) inside
            vfa_pkg::OP_ADD, vfa_pkg::OP_SUB, vfa_pkg::OP_NEG: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_d3.op == vfa_pkg::OP_ADD) begin
                        rs = sat33({r_d3.a[i][31], r_d3.a[i]} + {r_d3.b[i][31], r_d3.b[i]});
                    end else if (r_d3.op == vfa_pkg::OP_SUB) begin
                        rs = sat33({r_d3.a[i][31], r_d3.a[i]} - {r_d3.b[i][31], r_d3.b[i]});
                    end else begin
                        rs = sat33(33'sd0 - {r_d3.b[i][31], r_d3.b[i]});
                    end
                    n_m4.res[i] = rs[31:0];
                    n_m4.ov     = n_m4.ov | rs[32];
                end
            end
            vfa_pkg::OP_MUL, vfa_pkg::OP_SCALE, vfa_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    rs          = round_sat({r_p3[i][64], r_p3[i]});
                    n_m4.res[i] = rs[31:0];
                    n_m4.ov     = n_m4.ov | rs[32];
                end
            end
            vfa_pkg::OP_DOT, vfa_pkg::OP_LENSQ: begin
                rs      = round_sat(r_dot3);
                n_m4.sc = rs[31:0];
                n_m4.ov = rs[32];
            end
            vfa_pkg::OP_GET: begin
                case (r_d3.idx)
                    2'd0:    n_m4.sc = r_d3.b[0];
                    2'd1:    n_m4.sc = r_d3.b[1];
                    2'd2:    n_m4.sc = r_d3.b[2];
                    default: n_m4.sc = '0;
                endcase
            end
            vfa_pkg::OP_SET: begin
                n_m4.res = r_d3.b;
                case (r_d3.idx)
                    2'd0:    n_m4.res[0] = r_d3.s;
                    2'd1:    n_m4.res[1] = r_d3.s;
                    2'd2:    n_m4.res[2] = r_d3.s;
                    default: n_m4.res    = r_d3.b;
                endcase
            end
            default: begin
                n_m4.sc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m4  <= n_m4;
            r_sq4 <= r_dot3[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // vector length
    vfa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v4),
        .i_x     (r_sq4),
        .i_pay   (r_m4),
        .o_valid (sq_v),
        .o_root  (sq_len),
        .o_pay   (sq_pay)
    );

    // clamp the length result and mark divide ops
    always_comb begin
        n_fin.use_div = (sq_pay.op == vfa_pkg::OP_DIV) || (sq_pay.op == vfa_pkg::OP_UNIT);
        n_fin.res     = sq_pay.res;
        n_fin.sc      = sq_pay.sc;
        n_fin.ov      = sq_pay.ov;
        if (sq_pay.op == vfa_pkg::OP_LEN) begin
            if (sq_len[32] || sq_len[31]) begin
                n_fin.sc = vfa_pkg::W32_MAX;
                n_fin.ov = 1'b1;
            end else begin
                n_fin.sc = sq_len[31:0];
            end
        end
    end

    // divider lanes
    for (genvar i = 0; i < 3; i++) begin : g_div
        logic signed [33:0] den;
        assign den = (sq_pay.op == vfa_pkg::OP_UNIT) ? {1'b0, sq_len}
                                                     : {{2{sq_pay.s[31]}}, sq_pay.s};
        vfa_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (sq_pay.b[i]),
            .i_den (den),
            .o_res (dres[i])
        );
    end

    // hold the other results beside the dividers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fin[0] <= n_fin;
            for (int k = 1; k < DL; k++) begin
                r_fin[k] <= r_fin[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_fv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_fv[0] <= sq_v;
            for (int k = 1; k < DL; k++) begin
                r_fv[k] <= r_fv[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_fin[DL-1].use_div) begin
                for (int i = 0; i < 3; i++) begin
                    r_res[i] <= dres[i].q;
                end
                r_sc <= '0;
                r_ov <= dres[0].ovf | dres[1].ovf | dres[2].ovf;
                r_dz <= dres[0].dz | dres[1].dz | dres[2].dz;
            end else begin
                r_res <= r_fin[DL-1].res;
                r_sc  <= r_fin[DL-1].sc;
                r_ov  <= r_fin[DL-1].ov;
                r_dz  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_fv[DL-1];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_dz, r_ov, r_sc, r_res};

    // a zero divisor is shared by all lanes, so it never comes with a saturation
    `VFA_ASSERT_IMP(a_dz_excludes_ovf, r_out_valid, !(r_ov && r_dz))
    // an accepted beat enters the first stage
    `VFA_ASSERT_NEXT(a_accept_loads, i_s_axis_tvalid && o_s_axis_tready, r_v0)
    // unused op codes leave every result field clear
    `VFA_ASSERT_IMP(a_unused_op_clear, r_v4 && (r_m4.op > vfa_pkg::OP_SET),
        (r_m4.res == '0) && (r_m4.sc == '0) && !r_m4.ov)

endmodule
`default_nettype wire
